[sv/mnfp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the modem notification field parser.
// Used by every module of the block; depends on nothing.
package mnfp_pkg;

    // Parser phases, which double as the field tags of the results.
    localparam logic [2:0] PH_PLUS = 3'd0;
    localparam logic [2:0] PH_CMD  = 3'd1;
    localparam logic [2:0] PH_F1   = 3'd2;
    localparam logic [2:0] PH_F2   = 3'd3;
    localparam logic [2:0] PH_F3   = 3'd4;
    localparam logic [2:0] PH_TEXT = 3'd5;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int MAX_CMD_LEN_DEF   = 16;
    localparam int MAX_FIELD_LEN_DEF = 32;
    localparam int MAX_TEXT_LEN_DEF  = 160;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam int COUNT_W = 8;

    // A classified item as it travels from the front to the back.
    typedef struct packed {
        logic       req;
        logic [7:0] byte_v;
        logic       is_plus;
        logic       is_colon;
        logic       is_comma;
        logic       is_space;
        logic       is_eol;
    } t_item;

endpackage

[sv/modem_notification_field_parser_unit.sv]
`timescale 1ns / 1ps
// Modem notification field parser, top level.
// Input channel: i_in_valid / o_in_ready with i_req_type and i_byte_value. A request
// of type 1 restarts the parser; type 0 feeds one received byte.
// Output channel: o_out_valid / i_out_ready. Every accepted item yields exactly one
// result: the field tag, the stored character with its position, the field end and
// abort flags, and the sticky completed flag.
// The result is registered in turn by the front register, the queue and the back
// stage's result register. Throughput is one item per cycle while the receiver takes
// results, since the back stage updates its phase and count for each item it takes.
// The queue between front and back holds QUEUE_DEPTH items, so the input keeps
// flowing while the receiver stalls; once the queue and both stage registers are
// full, o_in_ready drops until results are taken.
// Synchronous reset (i_rst_n low) empties the pipeline, puts the parser in the
// wait-for-plus phase and clears the count and the completed flag.
// Depends on mnfp_pkg, mnfp_front, mnfp_queue and mnfp_back.
module modem_notification_field_parser_unit import mnfp_pkg::*; #(
    parameter int MAX_CMD_LEN   = MAX_CMD_LEN_DEF,
    parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF,
    parameter int MAX_TEXT_LEN  = MAX_TEXT_LEN_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_field_tag,
    output logic       o_char_stored,
    output logic [7:0] o_char_out,
    output logic [7:0] o_char_pos,
    output logic       o_field_end,
    output logic       o_aborted,
    output logic       o_completed
);

    logic  front_valid;
    logic  front_ready;
    t_item front_item;
    logic  queue_valid;
    logic  queue_ready;
    t_item queue_item;

    mnfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_req_type  (i_req_type),
        .i_byte_value(i_byte_value),
        .o_valid     (front_valid),
        .i_ready     (front_ready),
        .o_item      (front_item)
    );

    mnfp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_valid(front_valid),
        .o_wr_ready(front_ready),
        .i_wr_item (front_item),
        .o_rd_valid(queue_valid),
        .i_rd_ready(queue_ready),
        .o_rd_item (queue_item)
    );

    mnfp_back #(
        .MAX_CMD_LEN  (MAX_CMD_LEN),
        .MAX_FIELD_LEN(MAX_FIELD_LEN),
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .o_ready      (queue_ready),
        .i_item       (queue_item),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_field_tag  (o_field_tag),
        .o_char_stored(o_char_stored),
        .o_char_out   (o_char_out),
        .o_char_pos   (o_char_pos),
        .o_field_end  (o_field_end),
        .o_aborted    (o_aborted),
        .o_completed  (o_completed)
    );

endmodule

[sv/mnfp_front.sv]
`timescale 1ns / 1ps
// Front stage: accepts input items and registers them with their character class.
// Depends on mnfp_pkg.
module mnfp_front import mnfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_byte_value,
    output logic       o_valid,
    input  logic       i_ready,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.req      = i_req_type;
        n_item.byte_v   = i_byte_value;
        n_item.is_plus  = (i_byte_value == CH_PLUS);
        n_item.is_colon = (i_byte_value == CH_COLON);
        n_item.is_comma = (i_byte_value == CH_COMMA);
        n_item.is_space = (i_byte_value == CH_SPACE);
        n_item.is_eol   = (i_byte_value == CH_CR) || (i_byte_value == CH_LF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

[sv/mnfp_queue.sv]
`timescale 1ns / 1ps
// Short first-word-fall-through queue between the front and the back.
// Depends on mnfp_pkg for the item type.
module mnfp_queue import mnfp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_valid,
    output logic  o_wr_ready,
    input  t_item i_wr_item,
    output logic  o_rd_valid,
    input  logic  i_rd_ready,
    output t_item o_rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_wr_ready = (r_count != FULL_CNT);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

[sv/mnfp_back.sv]
`timescale 1ns / 1ps
// Back stage: runs the phase and count state machine and holds the result register.
// Depends on mnfp_pkg.
module mnfp_back import mnfp_pkg::*; #(
    parameter int MAX_CMD_LEN   = MAX_CMD_LEN_DEF,
    parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF,
    parameter int MAX_TEXT_LEN  = MAX_TEXT_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_field_tag,
    output logic       o_char_stored,
    output logic [7:0] o_char_out,
    output logic [7:0] o_char_pos,
    output logic       o_field_end,
    output logic       o_aborted,
    output logic       o_completed
);

    localparam logic [COUNT_W:0] LIM_CMD  = (COUNT_W+1)'(MAX_CMD_LEN);
    localparam logic [COUNT_W:0] LIM_F1   = (COUNT_W+1)'(MAX_FIELD_LEN + 1);
    localparam logic [COUNT_W:0] LIM_FLD  = (COUNT_W+1)'(MAX_FIELD_LEN);
    localparam logic [COUNT_W:0] LIM_TEXT = (COUNT_W+1)'(MAX_TEXT_LEN);

    logic [2:0]         r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_done, n_done;
    logic               r_out_valid;

    logic [2:0]         n_tag;
    logic               n_stored;
    logic [7:0]         n_char;
    logic [7:0]         n_pos;
    logic               n_end;
    logic               n_abort;

    logic               do_store;
    logic [COUNT_W:0]   limit;
    logic [7:0]         store_pos;
    logic [COUNT_W:0]   count_inc;
    logic               take;

    assign o_ready   = !r_out_valid || i_ready;
    assign take      = i_valid && o_ready;
    assign count_inc = {1'b0, r_count} + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_done    = r_done;
        n_tag     = PH_PLUS;
        n_end     = 1'b0;
        n_abort   = 1'b0;
        do_store  = 1'b0;
        limit     = LIM_CMD;
        store_pos = r_count;
        if (i_item.req) begin
            n_phase = PH_PLUS;
            n_count = '0;
            n_done  = 1'b0;
        end else begin
            case (r_phase)
                PH_CMD: begin
                    n_tag = PH_CMD;
                    if (i_item.is_colon) begin
                        n_end   = 1'b1;
                        n_count = '0;
                        n_phase = PH_F1;
                    end else begin
                        do_store = 1'b1;
                        limit    = LIM_CMD;
                    end
                end
                PH_F1: begin
                    n_tag = PH_F1;
                    if (r_count == '0) begin
                        // The first field must open with a space, which is not stored.
                        if (!i_item.is_space) begin
                            n_phase = PH_PLUS;
                            n_count = '0;
                            n_abort = 1'b1;
                        end else begin
                            n_count = COUNT_W'(1);
                        end
                    end else if (i_item.is_comma) begin
                        n_end   = 1'b1;
                        n_count = '0;
                        n_phase = PH_F2;
                    end else begin
                        do_store  = 1'b1;
                        limit     = LIM_F1;
                        store_pos = r_count - 1'b1;
                    end
                end
                PH_F2: begin
                    n_tag = PH_F2;
                    if (i_item.is_comma) begin
                        n_end   = 1'b1;
                        n_count = '0;
                        n_phase = PH_F3;
                    end else begin
                        do_store = 1'b1;
                        limit    = LIM_FLD;
                    end
                end
                PH_F3: begin
                    n_tag = PH_F3;
                    if (i_item.is_eol) begin
                        n_end   = 1'b1;
                        n_count = '0;
                        n_phase = PH_TEXT;
                    end else begin
                        do_store = 1'b1;
                        limit    = LIM_FLD;
                    end
                end
                PH_TEXT: begin
                    n_tag = PH_TEXT;
                    // Line ends before any text are skipped; later ones finish the text.
                    if (i_item.is_eol) begin
                        if (r_count != '0) begin
                            n_end  = 1'b1;
                            n_done = 1'b1;
                        end
                    end else begin
                        do_store = 1'b1;
                        limit    = LIM_TEXT;
                    end
                end
                default: begin
                    if (i_item.is_plus) begin
                        n_count = '0;
                        n_phase = PH_CMD;
                    end else begin
                        n_phase = PH_PLUS;
                    end
                end
            endcase
            if (do_store) begin
                if (count_inc > limit) begin
                    n_phase = PH_PLUS;
                    n_count = '0;
                    n_abort = 1'b1;
                end else begin
                    n_count = count_inc[COUNT_W-1:0];
                end
            end
        end
        n_stored = do_store;
        n_char   = do_store ? i_item.byte_v : 8'd0;
        n_pos    = do_store ? store_pos : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PLUS;
            r_count     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_done  <= n_done;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_field_tag   <= n_tag;
            o_char_stored <= n_stored;
            o_char_out    <= n_char;
            o_char_pos    <= n_pos;
            o_field_end   <= n_end;
            o_aborted     <= n_abort;
            o_completed   <= n_done;
        end
    end

    assign o_valid = r_out_valid;

endmodule

[sv/mnfp_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the parser results, bound to the top level.
// Depends on mnfp_pkg and modem_notification_field_parser_unit.
module mnfp_checker import mnfp_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_field_tag,
    input logic       o_char_stored,
    input logic [7:0] o_char_out,
    input logic [7:0] o_char_pos,
    input logic       o_field_end,
    input logic       o_aborted,
    input logic       o_completed
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_char_out)
            && $stable(o_field_tag) && $stable(o_completed))
        else $error("result changed while stalled");

    // Nothing is stored while waiting for the plus sign or after a restart.
    a_tag_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_tag == PH_PLUS |-> !o_char_stored && !o_field_end
            && !o_aborted)
        else $error("activity reported with no field tag");

    // A byte that ends a field is never stored and never aborts.
    a_end_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_end |-> !o_char_stored && !o_aborted)
        else $error("field end combined with store or abort");

    // The end of the text always leaves the completed flag set.
    a_text_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_end && o_field_tag == PH_TEXT |-> o_completed)
        else $error("text end without completed flag");

    // An unstored result carries zero character and position.
    a_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_char_stored |-> o_char_out == 8'd0 && o_char_pos == 8'd0)
        else $error("character data without store");

endmodule

bind modem_notification_field_parser_unit mnfp_checker u_mnfp_checker (.*);
